/* design/sps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the servo pulse slew limiter
// Payload structs for the request and response channels, the command word
// that travels from front to back, the register file layout and reset values.
// ----------------------------------------------------------------------------
package sps_pkg;

   // field widths fixed by the channel format
   localparam int CHANNEL_W = 6;
   localparam int PULSE_W   = 12;
   localparam int REQ_W     = 16;
   localparam int CSR_IDX_W = 3;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [PULSE_W-1:0] PULSE_FLOOR_RST      = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_CEILING_RST    = 12'd2500;
   localparam logic [PULSE_W-1:0] NEUTRAL_PULSE_RST    = 12'd1500;
   localparam logic [PULSE_W-1:0] MAX_STEP_RST         = 12'd120;
   localparam logic [PULSE_W-1:0] SMALL_MOVE_LIMIT_RST = 12'd50;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_FLOOR      = 3'd0,
      CSR_PULSE_CEILING    = 3'd1,
      CSR_NEUTRAL_PULSE    = 3'd2,
      CSR_MAX_STEP         = 3'd3,
      CSR_SMALL_MOVE_LIMIT = 3'd4
   } csr_index_type;

   // request payload
   typedef struct packed {
      logic [CHANNEL_W-1:0]     channel;
      logic signed [REQ_W-1:0]  requested_pulse;
   } req_type;

   // response payload
   typedef struct packed {
      logic                 accepted;
      logic [CHANNEL_W-1:0] out_channel;
      logic [PULSE_W-1:0]   issued_pulse;
      logic                 was_limited;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic                 ok;
      logic [CHANNEL_W-1:0] channel;
      logic [PULSE_W-1:0]   target;
   } cmd_type;

   // configuration register file
   typedef struct packed {
      logic [PULSE_W-1:0] pulse_floor;
      logic [PULSE_W-1:0] pulse_ceiling;
      logic [PULSE_W-1:0] neutral_pulse;
      logic [PULSE_W-1:0] max_step;
      logic [PULSE_W-1:0] small_move_limit;
   } cfg_type;

endpackage

/* design/sps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_front: request intake and classification
// Checks the channel number, clamps the requested pulse to the configured
// bounds and pushes the resulting command into the queue.
// ----------------------------------------------------------------------------
module sps_front #(
   parameter int CHANNELS = 32
) (
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sps_pkg::req_type                     req_data,
   input  logic [sps_pkg::PULSE_W-1:0]          pulse_floor,
   input  logic [sps_pkg::PULSE_W-1:0]          pulse_ceiling,
   input  logic                                 queue_full,
   output logic                                 push,
   output sps_pkg::cmd_type                     push_data
);

   logic                                 ch_ok;
   logic signed [sps_pkg::REQ_W:0]       req_ext;
   logic signed [sps_pkg::REQ_W:0]       lo_ext;
   logic signed [sps_pkg::REQ_W:0]       hi_ext;
   logic [sps_pkg::PULSE_W-1:0]          target;

   // intake handshake: stall only when the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // channel must lie in 1 .. CHANNELS
   assign ch_ok = (req_data.channel != '0) &&
                  (req_data.channel <= sps_pkg::CHANNEL_W'(CHANNELS));

   // clamp, floor first; crossed bounds give the floor below it, else the ceiling
   assign req_ext = {req_data.requested_pulse[sps_pkg::REQ_W-1], req_data.requested_pulse};
   assign lo_ext  = $signed({{(sps_pkg::REQ_W+1-sps_pkg::PULSE_W){1'b0}}, pulse_floor});
   assign hi_ext  = $signed({{(sps_pkg::REQ_W+1-sps_pkg::PULSE_W){1'b0}}, pulse_ceiling});

   always_comb begin
      if (req_ext < lo_ext) begin
         target = pulse_floor;
      end else if (req_ext > hi_ext) begin
         target = pulse_ceiling;
      end else begin
         target = req_data.requested_pulse[sps_pkg::PULSE_W-1:0];
      end
   end

   // command word
   always_comb begin
      push_data.ok      = ch_ok;
      push_data.channel = req_data.channel;
      push_data.target  = target;
   end

endmodule

/* design/sps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_queue: short command queue between front and back
// Small register fifo; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sps_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             head_valid,
   output sps_pkg::cmd_type head_data,
   output logic             full
);

   localparam int PTR_W = (sps_pkg::QUEUE_DEPTH > 1) ? $clog2(sps_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(sps_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sps_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sps_pkg::QUEUE_DEPTH);

   sps_pkg::cmd_type   slots_ff [sps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];
   assign full       = (count_ff == DEPTH_CNT);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/sps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_back: per-channel slew limiting and response register
// Reads the channel's last pulse from a small memory, limits the step,
// writes the new pulse back and presents the response. A write in the same
// cycle as a read of the same channel is forwarded.
// ----------------------------------------------------------------------------
module sps_back #(
   parameter int CHANNELS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sps_pkg::cmd_type head_data,
   output logic             pop,
   input  sps_pkg::cfg_type cfg,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sps_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW    = sps_pkg::PULSE_W;

   // pulse memory and written flags
   logic [PW-1:0]       mem [CHANNELS];
   logic [CHANNELS-1:0] written_ff, written_in;

   // limiter stage
   logic                b_valid_ff, b_valid_in;
   sps_pkg::cmd_type    b_cmd_ff;
   logic [PW-1:0]       mem_q_ff;
   logic                byp_ff;
   logic [PW-1:0]       byp_val_ff;

   // response register
   logic                out_valid_ff, out_valid_in;
   sps_pkg::rsp_type    out_data_ff;

   logic                out_ready, b_fire, b_load, wr_en;
   logic [IDX_W-1:0]    head_addr, b_addr;
   logic [PW-1:0]       last, step, issued;
   logic signed [PW:0]  delta;
   logic [PW-1:0]       mag;
   logic                limited;
   sps_pkg::rsp_type    result;

   // stage control
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign b_fire    = b_valid_ff && out_ready;
   assign b_load    = !b_valid_ff || b_fire;
   assign pop       = head_valid && b_load;
   assign wr_en     = b_fire && b_cmd_ff.ok;

   // memory addresses, parked at zero for rejected channels
   assign head_addr = head_data.ok ? IDX_W'(head_data.channel - 1'b1) : '0;
   assign b_addr    = b_cmd_ff.ok  ? IDX_W'(b_cmd_ff.channel - 1'b1)  : '0;

   // last pulse: forwarded write, stored value or neutral
   always_comb begin
      if (byp_ff) begin
         last = byp_val_ff;
      end else if (written_ff[b_addr]) begin
         last = mem_q_ff;
      end else begin
         last = cfg.neutral_pulse;
      end
   end

   // step limit
   always_comb begin
      delta   = $signed({1'b0, b_cmd_ff.target}) - $signed({1'b0, last});
      mag     = delta[PW] ? PW'(-delta) : delta[PW-1:0];
      step    = (mag < cfg.small_move_limit) ? {1'b0, cfg.max_step[PW-1:1]} : cfg.max_step;
      limited = (mag > step);
      if (limited) begin
         issued = delta[PW] ? last - step : last + step;
      end else begin
         issued = b_cmd_ff.target;
      end
   end

   // response word
   always_comb begin
      result.out_channel = b_cmd_ff.channel;
      if (b_cmd_ff.ok) begin
         result.accepted     = 1'b1;
         result.issued_pulse = issued;
         result.was_limited  = limited;
      end else begin
         result.accepted     = 1'b0;
         result.issued_pulse = '0;
         result.was_limited  = 1'b0;
      end
   end

   // control next state
   always_comb begin
      b_valid_in   = b_load ? head_valid : b_valid_ff;
      out_valid_in = out_ready ? b_valid_ff : out_valid_ff;
      written_in   = written_ff;
      if (wr_en) begin
         written_in[b_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         written_ff   <= written_in;
      end
   end

   // stage payload, memory read and forwarding capture
   always_ff @(posedge clock) begin
      if (b_load) begin
         b_cmd_ff   <= head_data;
         mem_q_ff   <= mem[head_addr];
         byp_ff     <= wr_en && head_data.ok && (b_addr == head_addr);
         byp_val_ff <= issued;
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[b_addr] <= issued;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* design/servo_pulse_slew_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_slew_limiter: per-channel servo pulse slew limiter
// Each request names a channel and a pulse width; one response is returned
// per request with the clamped, step-limited pulse, or a reject for a channel
// outside 1 .. CHANNELS.
//
// Usage:
//  - request channel req_valid / req_stall / req_data, response channel
//    rsp_valid / rsp_stall / rsp_data; a transfer happens when valid is high
//    and stall is low
//  - registers are written through csr_write_en / csr_index / csr_wdata while
//    no request is in flight
//  - path: command queue, limiter stage, response register; throughput: one
//    request per cycle unless rsp_stall holds it; the back end reads and writes
//    the per-channel pulse memory once per cycle, with same-channel forwarding
//  - req_stall rises only when the two-entry command queue is full; with the
//    response side stalled, four requests are held before intake stops
//  - reset restores the register defaults and marks every channel as never
//    written, so its last pulse reads as neutral_pulse; no memory sweep
// ----------------------------------------------------------------------------
module servo_pulse_slew_limiter #(
   parameter int CHANNELS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sps_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sps_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [sps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sps_pkg::PULSE_W-1:0]         csr_wdata
);

   sps_pkg::cfg_type cfg_ff, cfg_in;
   logic             push, pop, queue_full, head_valid;
   sps_pkg::cmd_type push_data, head_data;

   // register file write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            sps_pkg::CSR_PULSE_FLOOR:      cfg_in.pulse_floor      = csr_wdata;
            sps_pkg::CSR_PULSE_CEILING:    cfg_in.pulse_ceiling    = csr_wdata;
            sps_pkg::CSR_NEUTRAL_PULSE:    cfg_in.neutral_pulse    = csr_wdata;
            sps_pkg::CSR_MAX_STEP:         cfg_in.max_step         = csr_wdata;
            sps_pkg::CSR_SMALL_MOVE_LIMIT: cfg_in.small_move_limit = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_floor      <= sps_pkg::PULSE_FLOOR_RST;
         cfg_ff.pulse_ceiling    <= sps_pkg::PULSE_CEILING_RST;
         cfg_ff.neutral_pulse    <= sps_pkg::NEUTRAL_PULSE_RST;
         cfg_ff.max_step         <= sps_pkg::MAX_STEP_RST;
         cfg_ff.small_move_limit <= sps_pkg::SMALL_MOVE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake and clamp
   sps_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .pulse_floor   (cfg_ff.pulse_floor),
      .pulse_ceiling (cfg_ff.pulse_ceiling),
      .queue_full    (queue_full),
      .push          (push),
      .push_data     (push_data)
   );

   // command queue
   sps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   // slew limit and response
   sps_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // queue is only drained when it holds a command
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   // an accepted response always belongs to an existing channel
   a_accept_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         (rsp_data.out_channel != '0) &&
         (rsp_data.out_channel <= sps_pkg::CHANNEL_W'(CHANNELS)))
      else $error("accepted response on a channel out of range");

   // a rejected response carries no pulse and no limit flag
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         (rsp_data.issued_pulse == '0) && !rsp_data.was_limited)
      else $error("rejected response carries a pulse");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
